// File: hdl/cpu_return_bus_sequencer_assert.svh
// Assertion macros used by the checker file of the return bus sequencer.
`ifndef CPU_RETURN_BUS_SEQUENCER_ASSERT_SVH
`define CPU_RETURN_BUS_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// Next-cycle implication, checked out of reset.
`define RBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

`endif

// File: hdl/rbs_pkg.sv
// Types and constants of the return bus sequencer.
`default_nettype none

package rbs_pkg;

  typedef struct packed {
    logic        action;
    logic [3:0]  condition;
    logic [7:0]  flags;
    logic [15:0] stack_start;
    logic        ready_req;
    logic [7:0]  data_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] address;
    logic        address_driven;
    logic [7:0]  status_byte;
    logic        status_driven;
    logic        sync;
    logic        dbin;
    logic        wait_flag;
    logic [15:0] stack_pointer;
    logic [15:0] return_target;
    logic        target_load;
    logic        fetch_next;
    logic        busy_res;
  } out_item_t;

  localparam logic [7:0] STATUS_STACK_READ = 8'h86;

  localparam logic [7:0] FLAG_S  = 8'h80;
  localparam logic [7:0] FLAG_Z  = 8'h40;
  localparam logic [7:0] FLAG_P  = 8'h04;
  localparam logic [7:0] FLAG_CY = 8'h01;

  localparam logic [3:0] COND_ALWAYS = 4'd0;
  localparam logic [3:0] COND_NZ     = 4'd1;
  localparam logic [3:0] COND_Z      = 4'd2;
  localparam logic [3:0] COND_NC     = 4'd3;
  localparam logic [3:0] COND_C      = 4'd4;
  localparam logic [3:0] COND_PO     = 4'd5;
  localparam logic [3:0] COND_PE     = 4'd6;
  localparam logic [3:0] COND_P      = 4'd7;
  localparam logic [3:0] COND_M      = 4'd8;

endpackage

`default_nettype wire

// File: hdl/rbs_in_if.sv
// Input channel: one T-state beat with valid/ready handshake.
`default_nettype none

interface rbs_in_if;
  import rbs_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

`default_nettype wire

// File: hdl/rbs_out_if.sv
// Result channel: one bus-state beat with valid/ready handshake.
`default_nettype none

interface rbs_out_if;
  import rbs_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

`default_nettype wire

// File: hdl/rbs_in_stage.sv
// Input register: captures one T-state beat and hands it to the sequencer.
`default_nettype none

module rbs_in_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire rbs_pkg::in_item_t data_i,
  input  wire logic             take_i,
  output logic                  valid_o,
  output rbs_pkg::in_item_t     data_o
);
  import rbs_pkg::*;

  logic     valid_q;
  in_item_t data_q;

  // Refill in the same cycle the held beat moves on.
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rbs_core.sv
// T-state sequencer: machine-cycle state, stack pointer and popped bytes.
`default_nettype none

module rbs_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire rbs_pkg::in_item_t item_i,
  output rbs_pkg::out_item_t     res_o
);
  import rbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_T5TAK = 4'd1,
    ST_T5NOT = 4'd2,
    ST_M2T1  = 4'd3,
    ST_M2T2  = 4'd4,
    ST_M2TW  = 4'd5,
    ST_M2T3  = 4'd6,
    ST_M3T1  = 4'd7,
    ST_M3T2  = 4'd8,
    ST_M3TW  = 4'd9,
    ST_M3T3  = 4'd10
  } step_e;

  step_e       step_q, step_d;
  logic [15:0] sp_q, sp_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] latch_q, latch_d;
  out_item_t   res;

  function automatic logic cond_taken(input logic [3:0] cc, input logic [7:0] f);
    logic t;
    case (cc)
      COND_ALWAYS: t = 1'b1;
      COND_NZ:     t = (f & FLAG_Z) == '0;
      COND_Z:      t = (f & FLAG_Z) != '0;
      COND_NC:     t = (f & FLAG_CY) == '0;
      COND_C:      t = (f & FLAG_CY) != '0;
      COND_PO:     t = (f & FLAG_P) == '0;
      COND_PE:     t = (f & FLAG_P) != '0;
      COND_P:      t = (f & FLAG_S) == '0;
      COND_M:      t = (f & FLAG_S) != '0;
      default:     t = 1'b0;
    endcase
    return t;
  endfunction

  always_comb begin
    res     = '0;
    step_d  = step_q;
    sp_d    = sp_q;
    low_d   = low_q;
    latch_d = latch_q;
    case (step_q)
      ST_T5TAK: begin
        res.busy_res = 1'b1;
        step_d       = ST_M2T1;
      end
      ST_T5NOT: begin
        res.fetch_next = 1'b1;
        step_d         = ST_IDLE;
      end
      ST_M2T1, ST_M3T1: begin
        latch_d            = sp_q;
        res.address        = sp_q;
        res.address_driven = 1'b1;
        res.status_byte    = STATUS_STACK_READ;
        res.status_driven  = 1'b1;
        res.sync           = 1'b1;
        res.busy_res       = 1'b1;
        step_d             = (step_q == ST_M2T1) ? ST_M2T2 : ST_M3T2;
      end
      ST_M2T2, ST_M3T2, ST_M2TW, ST_M3TW: begin
        // Advance SP once, in T2; wait states only hold.
        if (step_q == ST_M2T2 || step_q == ST_M3T2) begin
          sp_d = latch_q + 16'd1;
        end
        res.address        = latch_q;
        res.address_driven = 1'b1;
        res.dbin           = 1'b1;
        res.wait_flag      = (step_q == ST_M2TW || step_q == ST_M3TW);
        res.busy_res       = 1'b1;
        if (step_q == ST_M2T2 || step_q == ST_M2TW) begin
          step_d = item_i.ready_req ? ST_M2T3 : ST_M2TW;
        end else begin
          step_d = item_i.ready_req ? ST_M3T3 : ST_M3TW;
        end
      end
      ST_M2T3: begin
        low_d              = item_i.data_in;
        res.address        = latch_q;
        res.address_driven = 1'b1;
        res.dbin           = 1'b1;
        res.busy_res       = 1'b1;
        step_d             = ST_M3T1;
      end
      ST_M3T3: begin
        res.address        = latch_q;
        res.address_driven = 1'b1;
        res.dbin           = 1'b1;
        res.return_target  = {item_i.data_in, low_q};
        res.target_load    = 1'b1;
        res.fetch_next     = 1'b1;
        step_d             = ST_IDLE;
      end
      default: begin
        step_d = ST_IDLE;
        if (item_i.action) begin
          sp_d         = item_i.stack_start;
          res.busy_res = 1'b1;
          if (item_i.condition == COND_ALWAYS) begin
            step_d = ST_M2T1;
          end else if (cond_taken(item_i.condition, item_i.flags)) begin
            step_d = ST_T5TAK;
          end else begin
            step_d = ST_T5NOT;
          end
        end
      end
    endcase
    res.stack_pointer = sp_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      sp_q    <= '0;
      low_q   <= '0;
      latch_q <= '0;
    end else if (adv_i) begin
      step_q  <= step_d;
      sp_q    <= sp_d;
      low_q   <= low_d;
      latch_q <= latch_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rbs_out_stage.sv
// Result register: holds one bus-state beat until the receiver takes it.
`default_nettype none

module rbs_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire rbs_pkg::out_item_t data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output rbs_pkg::out_item_t      data_o
);
  import rbs_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cpu_return_bus_sequencer.sv
// Top level of the return bus sequencer.
//
// Use: feed one beat on item_i per processor T-state, starting with the
// beat that carries action = 1 at M1 T4 (condition, flags, stack_start).
// Each accepted beat gives exactly one beat on result_o with the merged
// bus outputs of that T-state: address, status, SYNC, DBIN, WAIT, SP, and
// in the final T3 the popped return target with target_load/fetch_next.
// ready_req of a beat is READY for that T-state; data_in is the bus byte.
// Path: a result beat goes through the input register, then the result
// register, before it appears on result_o.
// Throughput: one beat per cycle while result_o.ready is high; the
// next-state logic is one pass through the sequencer state between
// the two registers.
// Reset: the sequencer returns to idle with SP, popped byte and address
// latch cleared; both stages are empty.
// Stall: while result_o.ready is low the result beat holds, one more beat
// waits in the input register, then item_i.ready drops. Nothing is lost.
`default_nettype none

module cpu_return_bus_sequencer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rbs_in_if.sink      item_i,
  rbs_out_if.source   result_o
);
  import rbs_pkg::*;

  logic      in_valid;
  in_item_t  in_data;
  logic      out_ready;
  logic      adv;
  out_item_t res;

  assign adv = in_valid && out_ready;

  rbs_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_i.valid),
    .ready_o (item_i.ready),
    .data_i  (item_i.data),
    .take_i  (adv),
    .valid_o (in_valid),
    .data_o  (in_data)
  );

  rbs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_data),
    .res_o  (res)
  );

  rbs_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .data_i  (res),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (result_o.data)
  );

endmodule

`default_nettype wire

// File: hdl/rbs_checker.sv
// Port-level checks on the result channel of the return bus sequencer.
`default_nettype none

`include "cpu_return_bus_sequencer_assert.svh"

module rbs_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic               ready_i,
  input  wire rbs_pkg::out_item_t data_i
);
  import rbs_pkg::*;

  logic beat;
  logic stalled;
  logic t1_ok;
  logic load_ok;
  logic wait_ok;

  assign beat    = valid_i && ready_i;
  assign stalled = valid_i && !ready_i;
  assign t1_ok   = data_i.address_driven && data_i.status_driven && data_i.busy_res
                   && (data_i.status_byte == STATUS_STACK_READ);
  assign load_ok = data_i.fetch_next && !data_i.busy_res && data_i.dbin;
  assign wait_ok = data_i.dbin && data_i.address_driven && !data_i.sync;

  `RBS_ASSERT_NEXT(a_hold_stalled, stalled, valid_i)
  `RBS_ASSERT_NOW(a_t1_status, beat && data_i.sync, t1_ok)
  `RBS_ASSERT_NOW(a_load_ends, beat && data_i.target_load, load_ok)
  `RBS_ASSERT_NOW(a_wait_dbin, beat && data_i.wait_flag, wait_ok)

endmodule

bind cpu_return_bus_sequencer rbs_checker u_rbs_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (result_o.valid),
  .ready_i (result_o.ready),
  .data_i  (result_o.data)
);

`default_nettype wire
